/* rtl/ecf_pkg.sv */
// ----------------------------------------------------------------------------
// ecf_pkg
// Shared constants, result type and small helper functions for the
// epoch-millisecond to calendar-field converter.
// ----------------------------------------------------------------------------
package ecf_pkg;

  localparam int TIME_W = 54;
  localparam int ZONE_W = 11;
  localparam int U_W    = 55;
  localparam int TOD_W  = 27;
  localparam int Z_W    = 28;
  localparam int ERA_W  = 11;
  localparam int DOE_W  = 18;

  localparam int unsigned DAY_MS   = 86400000;
  localparam int unsigned ERA_DAYS = 146097;

  // 86400000 * (719468 + 1024 * 146097): day number becomes a non-negative day-of-era base
  localparam logic [U_W-1:0] DAY_BIAS = 55'd12987889574400000;

  localparam logic signed [TIME_W-1:0] TIME_LIMIT = 54'sd8640000000000000;
  localparam logic signed [TIME_W-1:0] NEG_LIMIT  = -54'sd8640000000000000;

  localparam logic [ERA_W:0] ERA_BIAS = 12'd1024;

  // rounded-up reciprocals for exact floor division by a constant
  localparam logic [18:0] REC_1460 = 19'd367720;  // shift 29
  localparam logic [18:0] REC_365  = 19'd367720;  // shift 27
  localparam logic [27:0] REC_1000 = 28'd137438954; // shift 37
  localparam logic [17:0] REC_60M  = 18'd139811;  // shift 23
  localparam logic [11:0] REC_60H  = 12'd2185;    // shift 17

  typedef struct packed {
    logic [19:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic        is_leap;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic        out_of_range;
  } cal_t;

  // first day of each month, counted from 1 March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] mod7(input logic [18:0] v);
    logic [20:0] w;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  s3;
    w  = {2'b00, v};
    s1 = 6'(w[2:0]) + 6'(w[5:3]) + 6'(w[8:6]) + 6'(w[11:9]) + 6'(w[14:12])
       + 6'(w[17:15]) + 6'(w[20:18]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    if (s3 >= 4'd7) begin
      s3 = s3 - 4'd7;
    end
    return s3[2:0];
  endfunction

endpackage

/* rtl/ecf_cdiv.sv */
// ----------------------------------------------------------------------------
// ecf_cdiv
// Pipelined restoring division by a constant, STEP quotient bits per stage,
// with a side payload carried alongside.
// ----------------------------------------------------------------------------
module ecf_cdiv #(
  parameter int          WIDTH   = 55,
  parameter int unsigned DIVISOR = 86400000,
  parameter int          STEP    = 4,
  parameter int          PAY_W   = 1,
  localparam int         REM_W   = $clog2(DIVISOR)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_num,
  input  logic [PAY_W-1:0] in_pay,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_quot,
  output logic [REM_W-1:0] out_rem,
  output logic [PAY_W-1:0] out_pay
);

  localparam int NST   = (WIDTH + STEP - 1) / STEP;
  localparam int ACC_W = NST * STEP;
  localparam logic [REM_W:0] DIV_V = (REM_W + 1)'(DIVISOR);

  function automatic logic [ACC_W+REM_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                      input logic [REM_W-1:0] rem);
    logic [ACC_W-1:0] a;
    logic [REM_W:0]   r2;
    logic [REM_W-1:0] r;
    a = acc;
    r = rem;
    for (int i = 0; i < STEP; i++) begin
      r2 = {r, a[ACC_W-1]};
      a  = {a[ACC_W-2:0], 1'b0};
      if (r2 >= DIV_V) begin
        r2   = r2 - DIV_V;
        a[0] = 1'b1;
      end
      r = r2[REM_W-1:0];
    end
    return {a, r};
  endfunction

  logic [NST-1:0]   v;
  logic [ACC_W-1:0] acc [NST];
  logic [REM_W-1:0] rem [NST];
  logic [PAY_W-1:0] pay [NST];
  logic [NST:0]     rdy;

  assign rdy[NST] = out_ready;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic                   v_in;
    logic [ACC_W-1:0]       acc_in;
    logic [REM_W-1:0]       rem_in;
    logic [PAY_W-1:0]       pay_in;
    logic [ACC_W+REM_W-1:0] nx;

    assign rdy[s] = !v[s] || rdy[s+1];

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign acc_in = ACC_W'(in_num);
      assign rem_in = '0;
      assign pay_in = in_pay;
    end else begin : g_next
      assign v_in   = v[s-1];
      assign acc_in = acc[s-1];
      assign rem_in = rem[s-1];
      assign pay_in = pay[s-1];
    end

    assign nx = div_step(acc_in, rem_in);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (rdy[s]) begin
        v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        acc[s] <= nx[ACC_W+REM_W-1:REM_W];
        rem[s] <= nx[REM_W-1:0];
        pay[s] <= pay_in;
      end
    end
  end

  assign out_valid = v[NST-1];
  assign out_quot  = acc[NST-1][WIDTH-1:0];
  assign out_rem   = rem[NST-1];
  assign out_pay   = pay[NST-1];

endmodule

/* rtl/ecf_front.sv */
// ----------------------------------------------------------------------------
// ecf_front
// Range check, zone shift and biasing of the time value to a non-negative
// count ahead of the day split.
// ----------------------------------------------------------------------------
module ecf_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ecf_pkg::TIME_W-1:0]     time_ms,
  input  logic                                  use_local,
  input  logic signed [ecf_pkg::ZONE_W-1:0]     zone,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ecf_pkg::U_W-1:0]               out_u,
  output logic                                  out_oor
);

  import ecf_pkg::*;

  logic                     v1;
  logic                     v2;
  logic                     rdy1;
  logic                     rdy2;
  logic signed [TIME_W-1:0] t1;
  logic                     oor1;
  logic signed [26:0]       off1;
  logic signed [26:0]       off_ms;
  logic [U_W-1:0]           u;
  logic                     oor2;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign off_ms = use_local ? 27'(27'(zone) * 27'sd60000) : 27'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      t1   <= time_ms;
      oor1 <= (time_ms > TIME_LIMIT) || (time_ms < NEG_LIMIT);
      off1 <= off_ms;
    end
    if (rdy2) begin
      u    <= {t1[TIME_W-1], t1} + {{28{off1[26]}}, off1} + DAY_BIAS;
      oor2 <= oor1;
    end
  end

  assign out_valid = v2;
  assign out_u     = u;
  assign out_oor   = oor2;

endmodule

/* rtl/ecf_civil.sv */
// ----------------------------------------------------------------------------
// ecf_civil
// Civil date from era and day of era, and hour, minute, second and
// millisecond from the time of day.
// ----------------------------------------------------------------------------
module ecf_civil (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ecf_pkg::ERA_W-1:0]     era,
  input  logic [ecf_pkg::DOE_W-1:0]     doe,
  input  logic [ecf_pkg::TOD_W-1:0]     tod,
  input  logic                          oor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ecf_pkg::cal_t                 out_cal
);

  import ecf_pkg::*;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1
  logic [DOE_W-1:0] c1_doe;
  logic [ERA_W-1:0] c1_era;
  logic [TOD_W-1:0] c1_tod;
  logic             c1_oor;
  logic [6:0]       c1_d1460;
  logic [2:0]       c1_dc;
  logic             c1_dlast;
  logic [2:0]       c1_wd;
  logic [16:0]      c1_qs;
  logic [36:0]      p_1460;
  logic [54:0]      p_1000;

  assign p_1460 = 37'(doe) * 37'(REC_1460);
  assign p_1000 = 55'(tod) * 55'(REC_1000);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      c1_doe   <= doe;
      c1_era   <= era;
      c1_tod   <= tod;
      c1_oor   <= oor;
      c1_d1460 <= p_1460[35:29];
      c1_dc    <= 3'(doe >= 18'd36524) + 3'(doe >= 18'd73048) + 3'(doe >= 18'd109572)
                + 3'(doe >= 18'd146096);
      c1_dlast <= (doe == 18'd146096);
      c1_wd    <= mod7(19'(doe) + 19'd3);
      c1_qs    <= p_1000[53:37];
    end
  end

  // stage 2
  logic [DOE_W-1:0] c2_doe;
  logic [ERA_W-1:0] c2_era;
  logic             c2_oor;
  logic [2:0]       c2_wd;
  logic [DOE_W-1:0] c2_tsum;
  logic [9:0]       c2_ms;
  logic [16:0]      c2_qs;
  logic [10:0]      c2_qm;
  logic [26:0]      ms_full;
  logic [34:0]      p_qm;

  assign ms_full = c1_tod - 27'(c1_qs) * 27'd1000;
  assign p_qm    = 35'(c1_qs) * 35'(REC_60M);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      c2_doe  <= c1_doe;
      c2_era  <= c1_era;
      c2_oor  <= c1_oor;
      c2_wd   <= c1_wd;
      c2_tsum <= c1_doe - 18'(c1_d1460) + 18'(c1_dc) - 18'(c1_dlast);
      c2_ms   <= ms_full[9:0];
      c2_qs   <= c1_qs;
      c2_qm   <= p_qm[33:23];
    end
  end

  // stage 3
  logic [DOE_W-1:0] c3_doe;
  logic [ERA_W-1:0] c3_era;
  logic             c3_oor;
  logic [2:0]       c3_wd;
  logic [8:0]       c3_yoe;
  logic [9:0]       c3_ms;
  logic [5:0]       c3_sec;
  logic [10:0]      c3_qm;
  logic [4:0]       c3_qh;
  logic [36:0]      p_yoe;
  logic [16:0]      sec_full;
  logic [22:0]      p_qh;

  assign p_yoe    = 37'(c2_tsum) * 37'(REC_365);
  assign sec_full = c2_qs - 17'(c2_qm) * 17'd60;
  assign p_qh     = 23'(c2_qm) * 23'(REC_60H);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      c3_doe <= c2_doe;
      c3_era <= c2_era;
      c3_oor <= c2_oor;
      c3_wd  <= c2_wd;
      c3_yoe <= p_yoe[35:27];
      c3_ms  <= c2_ms;
      c3_sec <= sec_full[5:0];
      c3_qm  <= c2_qm;
      c3_qh  <= p_qh[21:17];
    end
  end

  // stage 4
  logic [ERA_W-1:0] c4_era;
  logic             c4_oor;
  logic [2:0]       c4_wd;
  logic [8:0]       c4_yoe;
  logic [8:0]       c4_doy;
  logic [9:0]       c4_ms;
  logic [5:0]       c4_sec;
  logic [5:0]       c4_min;
  logic [4:0]       c4_hour;
  logic [1:0]       y100;
  logic [DOE_W-1:0] yr_base;
  logic [DOE_W-1:0] doy_full;
  logic [10:0]      min_full;

  assign y100     = 2'(c3_yoe >= 9'd100) + 2'(c3_yoe >= 9'd200) + 2'(c3_yoe >= 9'd300);
  assign yr_base  = 18'(c3_yoe) * 18'd365 + 18'(c3_yoe[8:2]) - 18'(y100);
  assign doy_full = c3_doe - yr_base;
  assign min_full = c3_qm - 11'(c3_qh) * 11'd60;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      c4_era  <= c3_era;
      c4_oor  <= c3_oor;
      c4_wd   <= c3_wd;
      c4_yoe  <= c3_yoe;
      c4_doy  <= doy_full[8:0];
      c4_ms   <= c3_ms;
      c4_sec  <= c3_sec;
      c4_min  <= min_full[5:0];
      c4_hour <= c3_qh;
    end
  end

  // stage 5
  logic [3:0]         mp;
  logic [8:0]         mstart;
  logic [8:0]         yy;
  logic               leap;
  logic signed [11:0] era_s;
  logic signed [19:0] year_s;
  cal_t               cal;
  cal_t               cal_q;

  always_comb begin
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      mp = mp + 4'(c4_doy >= month_start(4'(k)));
    end
  end

  assign mstart = month_start(mp);
  assign yy     = c4_yoe + 9'(mp >= 4'd10);
  assign leap   = (yy[1:0] == 2'b00) && !(yy == 9'd100 || yy == 9'd200 || yy == 9'd300);
  assign era_s  = $signed({1'b0, c4_era}) - $signed(ERA_BIAS);
  assign year_s = {{8{era_s[11]}}, era_s} * 20'sd400 + $signed({11'b0, yy});

  always_comb begin
    cal = '0;
    if (c4_oor) begin
      cal.out_of_range = 1'b1;
    end else begin
      cal.year         = year_s;
      cal.month        = (mp < 4'd10) ? mp + 4'd2 : mp - 4'd10;
      cal.day_of_month = 5'(c4_doy - mstart + 9'd1);
      cal.weekday      = c4_wd;
      cal.day_of_year  = (mp >= 4'd10) ? c4_doy - 9'd306 : c4_doy + 9'd59 + 9'(leap);
      cal.is_leap      = leap;
      cal.hour         = c4_hour;
      cal.minute       = c4_min;
      cal.second       = c4_sec;
      cal.millisecond  = c4_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      cal_q <= cal;
    end
  end

  assign out_valid = v5;
  assign out_cal   = cal_q;

endmodule

/* rtl/epoch_ms_to_calendar_fields.sv */
// ----------------------------------------------------------------------------
// epoch_ms_to_calendar_fields
// Signed epoch milliseconds to proleptic Gregorian calendar fields, with an
// optional local zone offset.
// ----------------------------------------------------------------------------
//  channel  | kind          | carries
//  s_axis   | stream in     | time_ms in tdata, use_local in tuser
//  m_axis   | stream out    | calendar fields in tdata, out_of_range in tuser
//  apb      | register port | zone_offset_minutes at address 0
//
//  One item per cycle while m_axis is not stalled. The pipeline has 2 front
//  stages, 14 stages of the day split (4 quotient bits each), 7 stages of the
//  era split and 5 stages of field assembly.
//  Reset clears the valid bits and the zone offset.
//  Each stage holds while the one after it is full and stalled.
// ----------------------------------------------------------------------------
module epoch_ms_to_calendar_fields (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // time_ms[53:0]
  input  logic        s_axis_tuser,  // use_local
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // year[19:0], month[23:20], day_of_month[28:24], weekday[31:29],
  // day_of_year[40:32], is_leap[41], hour[46:42], minute[52:47],
  // second[58:53], millisecond[68:59]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser   // out_of_range
);

  import ecf_pkg::*;

  localparam logic ADDR_ZONE = 1'b0;

  logic signed [ZONE_W-1:0] zone;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_ZONE) begin
      zone <= pwdata[ZONE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_ZONE) ? 32'(unsigned'(zone)) : 32'd0;

  logic             f_valid, f_ready, f_oor;
  logic [U_W-1:0]   f_u;
  logic             d1_valid, d1_ready;
  logic [U_W-1:0]   d1_quot;
  logic [TOD_W-1:0] d1_rem;
  logic             d1_oor;
  logic             d2_valid, d2_ready;
  logic [Z_W-1:0]   d2_quot;
  logic [DOE_W-1:0] d2_rem;
  logic [TOD_W:0]   d2_pay;
  cal_t             cal;

  ecf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .time_ms   ($signed(s_axis_tdata[TIME_W-1:0])),
    .use_local (s_axis_tuser),
    .zone      (zone),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_u     (f_u),
    .out_oor   (f_oor)
  );

  ecf_cdiv #(
    .WIDTH   (U_W),
    .DIVISOR (DAY_MS),
    .STEP    (4),
    .PAY_W   (1)
  ) u_day_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_num    (f_u),
    .in_pay    (f_oor),
    .out_valid (d1_valid),
    .out_ready (d1_ready),
    .out_quot  (d1_quot),
    .out_rem   (d1_rem),
    .out_pay   (d1_oor)
  );

  ecf_cdiv #(
    .WIDTH   (Z_W),
    .DIVISOR (ERA_DAYS),
    .STEP    (4),
    .PAY_W   (TOD_W + 1)
  ) u_era_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_valid),
    .in_ready  (d1_ready),
    .in_num    (d1_quot[Z_W-1:0]),
    .in_pay    ({d1_rem, d1_oor}),
    .out_valid (d2_valid),
    .out_ready (d2_ready),
    .out_quot  (d2_quot),
    .out_rem   (d2_rem),
    .out_pay   (d2_pay)
  );

  ecf_civil u_civil (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d2_valid),
    .in_ready  (d2_ready),
    .era       (d2_quot[ERA_W-1:0]),
    .doe       (d2_rem),
    .tod       (d2_pay[TOD_W:1]),
    .oor       (d2_pay[0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_cal   (cal)
  );

  assign m_axis_tdata = {3'b000, cal.millisecond, cal.second, cal.minute, cal.hour,
                         cal.is_leap, cal.day_of_year, cal.weekday, cal.day_of_month,
                         cal.month, cal.year};
  assign m_axis_tuser = cal.out_of_range;

endmodule

/* verif/tb_epoch_ms_to_calendar_fields.sv */
// ----------------------------------------------------------------------------
// tb_epoch_ms_to_calendar_fields
// Self-checking bench for the epoch-millisecond to calendar-field converter.
// A built-in calendar predictor computes the expected fields for every
// accepted item. A monitor compares each output item, field by field, with
// the oldest prediction. Random source gaps and sink stalls vary per phase,
// and the zone offset is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_epoch_ms_to_calendar_fields;
  import ecf_pkg::*;

  localparam longint LIMIT_MS = 64'sd8640000000000000;
  localparam longint DAY_LEN  = 64'sd86400000;
  localparam longint MIN_LEN  = 64'sd60000;

  typedef struct {
    logic [19:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [2:0]  wday;
    logic [8:0]  doy;
    logic        leap;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  msec;
    logic        oor;
  } fields_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;

  fields_t     pending_dates[$];
  logic [10:0] zone_model = '0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          n_sent = 0, n_checked = 0, n_oor = 0, n_fail = 0;

  epoch_ms_to_calendar_fields dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) < 0) q = q - 1;
    return q;
  endfunction

  function automatic fields_t calendar_of(logic [53:0] raw, logic loc, logic [10:0] zone);
    fields_t f;
    longint  t, days, tod, z, era, doe, yoe, y, dy, mp;
    bit      lp;
    f = '{default: '0};
    t = longint'(signed'(raw));
    if (t > LIMIT_MS || t < -LIMIT_MS) begin
      f.oor = 1'b1;
      return f;
    end
    if (loc) t = t + longint'(signed'(zone)) * MIN_LEN;
    days = floor_div(t, DAY_LEN);
    tod  = t - days * DAY_LEN;
    z    = days + 719468;
    era  = floor_div(z, 146097);
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    y    = yoe + era * 400;
    dy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * dy + 2) / 153;
    f.dom = 5'(dy - (153 * mp + 2) / 5 + 1);
    if (mp >= 10) y = y + 1;
    lp = ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    f.year  = 20'(y);
    f.month = 4'((mp < 10) ? mp + 2 : mp - 10);
    f.wday  = 3'(days + 4 - floor_div(days + 4, 7) * 7);
    f.doy   = 9'((mp >= 10) ? dy - 306 : dy + 59 + (lp ? 1 : 0));
    f.leap  = lp;
    f.hour   = 5'(tod / 3600000);
    f.minute = 6'((tod / 60000) % 60);
    f.second = 6'((tod / 1000) % 60);
    f.msec   = 10'(tod % 1000);
    return f;
  endfunction

  function automatic void compare_field(string name, longint exp, longint act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      n_fail++;
    end
  endfunction

  // sink side: random stalls, then compare against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    fields_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected output item, tdata %h", m_axis_tdata);
        n_fail++;
      end else begin
        e = pending_dates.pop_front();
        compare_field("year", e.year, m_axis_tdata[19:0]);
        compare_field("month", e.month, m_axis_tdata[23:20]);
        compare_field("day_of_month", e.dom, m_axis_tdata[28:24]);
        compare_field("weekday", e.wday, m_axis_tdata[31:29]);
        compare_field("day_of_year", e.doy, m_axis_tdata[40:32]);
        compare_field("is_leap", e.leap, m_axis_tdata[41]);
        compare_field("hour", e.hour, m_axis_tdata[46:42]);
        compare_field("minute", e.minute, m_axis_tdata[52:47]);
        compare_field("second", e.second, m_axis_tdata[58:53]);
        compare_field("millisecond", e.msec, m_axis_tdata[68:59]);
        compare_field("out_of_range", e.oor, m_axis_tuser);
        n_checked++;
        if (e.oor) n_oor++;
      end
    end
  end

  task automatic send_stamp(longint t, logic loc);
    logic r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, t[53:0]};
    s_axis_tuser  <= loc;
    do begin
      @(negedge clk);
      r = s_axis_tready;
      @(posedge clk);
    end while (!r);
    pending_dates.push_back(calendar_of(t[53:0], loc, zone_model));
    n_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_dates.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_zone(logic [2:0] addr, logic [31:0] value);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) zone_model = value[10:0];
    @(posedge clk);
  endtask

  function automatic longint rand_stamp();
    longint r;
    r = longint'({$urandom, $urandom});
    unique case ($urandom_range(9))
      0:       return r;                                   // any 54-bit pattern
      1:       return LIMIT_MS - longint'($urandom_range(200000000));
      2:       return -LIMIT_MS + longint'($urandom_range(200000000));
      3:       return longint'($urandom) - 64'sd2147483648; // near the epoch
      4:       return (r % 64'sd400000) * DAY_LEN + longint'($urandom_range(3)) - 2;
      5:       return LIMIT_MS + 1 + longint'($urandom_range(1000));
      default: return r % (LIMIT_MS + 1);
    endcase
  endfunction

  task automatic test_directed_extremes;
    longint stamps[12];
    stamps = '{0, -1, LIMIT_MS, -LIMIT_MS, LIMIT_MS + 1, -LIMIT_MS - 1,
               64'sd9007199254740991, -64'sd9007199254740992,
               64'sd951782400000, -64'sd2203891200000,
               64'sd946684799999, 64'sd86399999};
    foreach (stamps[i]) begin
      send_stamp(stamps[i], 1'b0);
      send_stamp(stamps[i], 1'b1);
    end
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    src_idle_pct  = idle;
    snk_stall_pct = stall;
    repeat (n) send_stamp(rand_stamp(), $urandom_range(1));
  endtask

  task automatic test_pause_until_empty;
    repeat (10) send_stamp(rand_stamp(), $urandom_range(1));
    drain();
    repeat (10) send_stamp(rand_stamp(), $urandom_range(1));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    write_zone(3'd0, 32'(-720));
    test_directed_extremes();
    write_zone(3'd0, 32'd840);
    test_random_phase(250, 0, 0);
    write_zone(3'd0, 32'd1023);
    send_stamp(LIMIT_MS, 1'b1);
    test_random_phase(250, 47, 0);
    write_zone(3'd0, 32'h0000_0400);
    send_stamp(-LIMIT_MS, 1'b1);
    test_random_phase(250, 0, 47);
    write_zone(3'd4, 32'hFFFF_FFFF);
    test_pause_until_empty();
    write_zone(3'd0, 32'($urandom_range(2047)) | 32'hFFFF_F800);
    test_random_phase(250, 30, 30);
    drain();
    $display("Sent %0d timestamps over four stall phases and six zone offsets,",
             n_sent);
    $display("checked %0d outputs, %0d of them out of range.", n_checked, n_oor);
    if (n_fail == 0 && pending_dates.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
